/* hdl/window_busy_time_meter_assert.svh */
// assertion macros for the busy time meter, clocked on clk, reset by arst_n
`ifndef WINDOW_BUSY_TIME_METER_ASSERT_SVH
`define WINDOW_BUSY_TIME_METER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define WBTM_ASSERT_IMPLIES(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("window_busy_time_meter: check failed");
// next-cycle implication
`define WBTM_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("window_busy_time_meter: check failed");
`else
`define WBTM_ASSERT_IMPLIES(lbl, pre, post)
`define WBTM_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

/* hdl/wbtm_pkg.sv */
package wbtm_pkg;

	// time stamp and window width
	localparam int TIME_BITS = 48;
	// width of the shared add/subtract unit: doubled remainder plus carry headroom
	localparam int UW        = TIME_BITS + 2;

	// basis point scale
	localparam int BP_W  = 14;
	localparam int QW    = BP_W + 1;
	localparam int BIT_W = $clog2(BP_W);
	localparam logic [BP_W-1:0] FULL_SCALE = BP_W'(10000);

	// stream packing
	localparam int IN_FIELDS_W  = TIME_BITS + 1;
	localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int IN_PAD       = IN_W - IN_FIELDS_W;
	localparam int OUT_FIELDS_W = TIME_BITS + BP_W + 1;
	localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD      = OUT_W - OUT_FIELDS_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = CFG_IDX_W'(1);

	// control of the shared unit
	typedef struct packed {
		logic sub;
	} alu_ctrl_t;

	// result of the shared unit
	typedef struct packed {
		logic [UW-1:0] value;
		logic          carry;
	} alu_res_t;

endpackage

/* hdl/wbtm_alu.sv */
module wbtm_alu
	import wbtm_pkg::*;
(
	input  logic [UW-1:0] x,
	input  logic [UW-1:0] y,
	input  alu_ctrl_t     ctrl,
	output alu_res_t      res
);

	logic [UW-1:0] y_eff;
	logic [UW:0]   full;

	// x + y, or x - y with carry meaning x >= y
	assign y_eff = ctrl.sub ? ~y : y;
	assign full  = {1'b0, x} + {1'b0, y_eff} + {{UW{1'b0}}, ctrl.sub};

	assign res.value = full[UW-1:0];
	assign res.carry = full[UW];

endmodule

/* hdl/window_busy_time_meter.sv */
// channel | dir | tdata fields (low bit up)                   | tlast      | tuser
// s_*     | in  | event_time[47:0], is_busy[48], zero pad      | last_event | none
// m_*     | out | busy_time[47:0], busy_basis_points[61:48],   | none       | none
//         |     | window_empty[62], zero pad                   |            |
// cfg_*   | in  | write enable, register index, write data     |            |
//
// all arithmetic runs through one 50-bit add/subtract unit under a small sequencer.
// an event with no busy interval to close stays in S_IDLE; closing one adds S_LO through S_ACC.
// a last event runs those again for a busy tail, then S_LEN, S_CMP and the
// 14-digit restoring division (5 extra add/reduce pairs; empty or full share ends early).
// arst_n clears the window registers, the sequence state and the output valid.
// a waiting result does not block input; only a second result waits for it.
module window_busy_time_meter
	import wbtm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // event_time, is_busy
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // busy_time, busy_basis_points, window_empty
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [TIME_BITS-1:0] cfg_wr_data
);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_LO   = 13'b0000000000010,
		S_HI   = 13'b0000000000100,
		S_DIFF = 13'b0000000001000,
		S_ACC  = 13'b0000000010000,
		S_LEN  = 13'b0000000100000,
		S_CMP  = 13'b0000001000000,
		S_DBL  = 13'b0000010000000,
		S_ADD  = 13'b0000100000000,
		S_RED  = 13'b0001000000000,
		S_FIN  = 13'b0010000000000,
		S_DONE = 13'b0100000000000,
		S_SPARE = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [TIME_BITS-1:0] win_start_q, win_end_q;
	logic [TIME_BITS-1:0] prev_time_q, acc_q;
	logic                 prev_busy_q, seen_q;
	logic                 last_q, tail_q;
	logic [TIME_BITS-1:0] a_q, b_q, lo_q, hi_q, amt_q, len_q, r_q;
	logic [TIME_BITS:0]   x_q;
	logic [QW-1:0]        q_q;
	logic [BIT_W-1:0]     bit_q;
	logic                 empty_q;
	logic [BP_W-1:0]      bp_q;

	logic                 out_valid_q;
	logic [TIME_BITS-1:0] out_time_q;
	logic [BP_W-1:0]      out_bp_q;
	logic                 out_empty_q;

	logic [UW-1:0] alu_x, alu_y;
	alu_ctrl_t     alu_ctrl;
	alu_res_t      alu_res;

	logic [TIME_BITS-1:0] in_time;
	logic                 in_busy;
	logic                 in_req;
	logic                 ge;
	logic [QW-1:0]        q_fin;
	logic                 out_load;

	assign in_time  = s_tdata[TIME_BITS-1:0];
	assign in_busy  = s_tdata[TIME_BITS];
	assign s_tready = (state_q == S_IDLE);
	assign in_req   = s_tvalid && s_tready;
	assign ge       = alu_res.carry;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, out_empty_q, out_bp_q, out_time_q};

	// final quotient with the last rounding step, saturated
	always_comb begin
		q_fin = q_q + {{(QW-1){1'b0}}, ge};
		if (q_fin > {1'b0, FULL_SCALE}) begin
			q_fin = {1'b0, FULL_SCALE};
		end
	end

	// operand select for the shared unit
	always_comb begin
		alu_x        = '0;
		alu_y        = '0;
		alu_ctrl.sub = 1'b1;
		unique case (state_q)
			S_LO: begin
				alu_x = UW'(a_q);
				alu_y = UW'(win_start_q);
			end
			S_HI: begin
				alu_x = UW'(b_q);
				alu_y = UW'(win_end_q);
			end
			S_DIFF: begin
				alu_x = UW'(hi_q);
				alu_y = UW'(lo_q);
			end
			S_ACC: begin
				alu_x        = UW'(acc_q);
				alu_y        = UW'(amt_q);
				alu_ctrl.sub = 1'b0;
			end
			S_LEN: begin
				alu_x = UW'(win_end_q);
				alu_y = UW'(win_start_q);
			end
			S_CMP: begin
				alu_x = UW'(acc_q);
				alu_y = UW'(len_q);
			end
			S_DBL, S_FIN: begin
				alu_x = UW'({r_q, 1'b0});
				alu_y = UW'(len_q);
			end
			S_ADD: begin
				alu_x        = UW'(r_q);
				alu_y        = UW'(acc_q);
				alu_ctrl.sub = 1'b0;
			end
			S_RED: begin
				alu_x = UW'(x_q);
				alu_y = UW'(len_q);
			end
			default: begin
				alu_ctrl.sub = 1'b1;
			end
		endcase
	end

	wbtm_alu u_alu (
		.x    (alu_x),
		.y    (alu_y),
		.ctrl (alu_ctrl),
		.res  (alu_res)
	);

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			win_end_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_WINDOW_START: win_start_q <= cfg_wr_data;
				REG_WINDOW_END:   win_end_q   <= cfg_wr_data;
				default:          win_start_q <= win_start_q;
			endcase
		end
	end

	// sequencer and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_time_q <= '0;
			prev_busy_q <= 1'b0;
			seen_q      <= 1'b0;
			acc_q       <= '0;
			last_q      <= 1'b0;
			tail_q      <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			amt_q       <= '0;
			len_q       <= '0;
			r_q         <= '0;
			x_q         <= '0;
			q_q         <= '0;
			bit_q       <= '0;
			empty_q     <= 1'b0;
			bp_q        <= '0;
			out_valid_q <= 1'b0;
			out_time_q  <= '0;
			out_bp_q    <= '0;
			out_empty_q <= 1'b0;
		end else begin
			// output valid: loaded by a finished result, cleared when taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_req) begin
						prev_time_q <= in_time;
						prev_busy_q <= in_busy;
						seen_q      <= 1'b1;
						last_q      <= s_tlast;
						if (seen_q && prev_busy_q) begin
							// close the interval from the previous event
							a_q     <= prev_time_q;
							b_q     <= in_time;
							tail_q  <= s_tlast && in_busy;
							state_q <= S_LO;
						end else if (s_tlast && in_busy) begin
							// busy tail up to the window end
							a_q     <= in_time;
							b_q     <= win_end_q;
							tail_q  <= 1'b0;
							state_q <= S_LO;
						end else if (s_tlast) begin
							tail_q  <= 1'b0;
							state_q <= S_LEN;
						end
					end
				end
				S_LO: begin
					lo_q    <= ge ? a_q : win_start_q;
					state_q <= S_HI;
				end
				S_HI: begin
					hi_q    <= ge ? win_end_q : b_q;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					amt_q   <= ge ? alu_res.value[TIME_BITS-1:0] : '0;
					state_q <= S_ACC;
				end
				S_ACC: begin
					// saturating accumulate
					acc_q <= alu_res.value[TIME_BITS] ? '1 : alu_res.value[TIME_BITS-1:0];
					if (tail_q) begin
						a_q     <= b_q;
						b_q     <= win_end_q;
						tail_q  <= 1'b0;
						state_q <= S_LO;
					end else if (last_q) begin
						state_q <= S_LEN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_LEN: begin
					len_q   <= alu_res.value[TIME_BITS-1:0];
					empty_q <= !ge || (alu_res.value[TIME_BITS-1:0] == '0);
					bp_q    <= '0;
					if (!ge || (alu_res.value[TIME_BITS-1:0] == '0)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					r_q   <= '0;
					q_q   <= '0;
					bit_q <= BIT_W'(BP_W - 1);
					if (ge) begin
						bp_q    <= FULL_SCALE;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DBL;
					end
				end
				S_DBL: begin
					// remainder doubles, quotient digit shifts in
					r_q <= ge ? alu_res.value[TIME_BITS-1:0] : {r_q[TIME_BITS-2:0], 1'b0};
					q_q <= {q_q[QW-2:0], 1'b0} + {{(QW-1){1'b0}}, ge};
					if (FULL_SCALE[bit_q]) begin
						state_q <= S_ADD;
					end else if (bit_q == '0) begin
						state_q <= S_FIN;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= S_DBL;
					end
				end
				S_ADD: begin
					x_q     <= alu_res.value[TIME_BITS:0];
					state_q <= S_RED;
				end
				S_RED: begin
					r_q <= ge ? alu_res.value[TIME_BITS-1:0] : x_q[TIME_BITS-1:0];
					q_q <= q_q + {{(QW-1){1'b0}}, ge};
					if (bit_q == '0) begin
						state_q <= S_FIN;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= S_DBL;
					end
				end
				S_FIN: begin
					bp_q    <= q_fin[BP_W-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hand over the result once the output register is free
					if (out_load) begin
						out_time_q  <= acc_q;
						out_bp_q    <= bp_q;
						out_empty_q <= empty_q;
						prev_time_q <= '0;
						prev_busy_q <= 1'b0;
						seen_q      <= 1'b0;
						acc_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`include "window_busy_time_meter_assert.svh"

	// share never exceeds full scale
	`WBTM_ASSERT_IMPLIES(a_bp_range, m_tvalid, m_tdata[TIME_BITS+BP_W-1:TIME_BITS] <= FULL_SCALE)
	// empty window reports a zero share
	`WBTM_ASSERT_IMPLIES(a_empty_zero, m_tvalid && out_empty_q, out_bp_q == '0)
	// a last event always starts the result work
	`WBTM_ASSERT_NEXT(a_last_busy, in_req && s_tlast, !s_tready)
	// digit counter stays within the quotient width
	`WBTM_ASSERT_IMPLIES(a_bit_range, state_q == S_DBL || state_q == S_RED, bit_q <= BIT_W'(BP_W - 1))

endmodule

/* sim/window_busy_time_meter_tb.sv */
module window_busy_time_meter_tb
	import wbtm_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [TIME_BITS-1:0] TIME_MAX    = '1;
	localparam int                   EVENT_GOAL  = 1350;
	localparam int                   CALM_TAIL   = 150;
	localparam int                   SETTLE      = 64;
	localparam int                   CYCLE_LIMIT = 500000;
	localparam int                   REPORT_MAX  = 10;

	// one state-change event waiting to be sent
	typedef struct {
		logic [TIME_BITS-1:0] stamp;
		logic                 busy;
		logic                 last;
	} busy_event_t;

	// one meter reading
	typedef struct {
		logic [TIME_BITS-1:0] busy_ticks;
		logic [BP_W-1:0]      share_bp;
		logic                 empty;
	} meter_reading_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [TIME_BITS-1:0] cfg_wr_data;

	busy_event_t    pending_events[$];
	meter_reading_t expected_readings[$];

	// shadow of the window registers and of the sequence state
	logic [TIME_BITS-1:0] win_lo;
	logic [TIME_BITS-1:0] win_hi;
	logic [TIME_BITS-1:0] held_stamp;
	logic                 held_busy;
	logic                 seq_open;
	logic [TIME_BITS-1:0] busy_sum;

	busy_event_t next_event;
	bit          in_taken;
	bit          calm;
	int          in_gap;
	int          out_gap;
	int          events_queued;
	int          events_taken;
	int          readings_seen;
	int          mismatches;
	int          phase_count;
	int          cycle_count;

	window_busy_time_meter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wr_data (cfg_wr_data)
	);

	// clock, 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [TIME_BITS-1:0] rand48();
		return TIME_BITS'({$urandom(), $urandom()});
	endfunction

	// part of [a, b] that lies inside the window
	function automatic logic [TIME_BITS-1:0] window_part(input logic [TIME_BITS-1:0] a,
			input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS-1:0] lo;
		logic [TIME_BITS-1:0] hi;
		lo = (a > win_lo) ? a : win_lo;
		hi = (b < win_hi) ? b : win_hi;
		return (hi > lo) ? hi - lo : '0;
	endfunction

	// saturating add into the busy sum
	task automatic add_busy(input logic [TIME_BITS-1:0] amount);
		if (amount > TIME_MAX - busy_sum)
			busy_sum = TIME_MAX;
		else
			busy_sum = busy_sum + amount;
	endtask

	// rounded share in basis points, halves going up
	function automatic logic [BP_W-1:0] share_of(input logic [TIME_BITS-1:0] ticks,
			input logic [TIME_BITS-1:0] span);
		logic [127:0] q;
		if (ticks >= span)
			return FULL_SCALE;
		q = (128'(ticks) * 128'd20000 + 128'(span)) / (128'(span) << 1);
		return (q > 128'(FULL_SCALE)) ? FULL_SCALE : q[BP_W-1:0];
	endfunction

	// update the shadow state for one accepted event, queue a reading on the last one
	task automatic meter_event(input logic [TIME_BITS-1:0] stamp, input logic busy,
			input logic last);
		meter_reading_t r;
		if (seq_open && held_busy)
			add_busy(window_part(held_stamp, stamp));
		held_stamp = stamp;
		held_busy  = busy;
		seq_open   = 1'b1;
		if (last) begin
			if (busy)
				add_busy(window_part(stamp, win_hi));
			r.empty      = (win_hi <= win_lo);
			r.busy_ticks = busy_sum;
			r.share_bp   = r.empty ? '0 : share_of(busy_sum, win_hi - win_lo);
			expected_readings.push_back(r);
			held_stamp = '0;
			held_busy  = 1'b0;
			seq_open   = 1'b0;
			busy_sum   = '0;
		end
	endtask

	// compare one reading from the block with the oldest expected one
	task automatic check_reading(input logic [OUT_W-1:0] data);
		meter_reading_t want;
		logic [TIME_BITS-1:0] got_ticks;
		logic [BP_W-1:0]      got_bp;
		logic                 got_empty;
		got_ticks = data[TIME_BITS-1:0];
		got_bp    = data[TIME_BITS+BP_W-1:TIME_BITS];
		got_empty = data[TIME_BITS+BP_W];
		readings_seen++;
		if (expected_readings.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("unexpected reading: ticks=%0d bp=%0d empty=%0d",
					got_ticks, got_bp, got_empty);
		end else begin
			want = expected_readings.pop_front();
			if (got_ticks !== want.busy_ticks || got_bp !== want.share_bp ||
					got_empty !== want.empty) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("reading %0d: expected ticks=%0d bp=%0d empty=%0d, got ticks=%0d bp=%0d empty=%0d",
						readings_seen, want.busy_ticks, want.share_bp, want.empty,
						got_ticks, got_bp, got_empty);
			end
		end
	endtask

	// sample both handshakes at the rising edge
	always @(posedge clk) begin
		in_taken = arst_n && s_tvalid && s_tready;
		if (in_taken) begin
			events_taken++;
			meter_event(s_tdata[TIME_BITS-1:0], s_tdata[TIME_BITS], s_tlast);
		end
		if (arst_n && m_tvalid && m_tready)
			check_reading(m_tdata);
	end

	// request driver and result receiver, both with random idle bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (in_gap > 0) begin
					in_gap--;
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					in_gap = $urandom_range(1, 10) - 1;
					s_tvalid <= 1'b0;
				end else if (pending_events.size() > 0) begin
					next_event = pending_events.pop_front();
					s_tdata  <= IN_W'({next_event.busy, next_event.stamp});
					s_tlast  <= next_event.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(1, 10) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d readings outstanding",
				cycle_count, expected_readings.size());
			$display("[window_busy_time_meter] ERROR");
			$finish;
		end
	end

	task automatic push_ev(input logic [TIME_BITS-1:0] stamp, input logic busy,
			input logic last);
		busy_event_t e;
		e.stamp = stamp;
		e.busy  = busy;
		e.last  = last;
		pending_events.push_back(e);
		events_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [TIME_BITS-1:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_addr    <= idx;
		cfg_wr_data <= value;
		if (idx == REG_WINDOW_START)
			win_lo = value;
		else
			win_hi = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_window(input logic [TIME_BITS-1:0] lo, input logic [TIME_BITS-1:0] hi);
		if ($urandom_range(0, 1)) begin
			write_reg(REG_WINDOW_START, lo);
			write_reg(REG_WINDOW_END, hi);
		end else begin
			write_reg(REG_WINDOW_END, hi);
			write_reg(REG_WINDOW_START, lo);
		end
	endtask

	// wait until every request is sent and every reading is back, then let the block settle
	task automatic wait_idle();
		while (pending_events.size() != 0 || s_tvalid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_window();
		logic [TIME_BITS-1:0] a;
		logic [TIME_BITS-1:0] b;
		a = rand48();
		b = rand48();
		case ($urandom_range(0, 9))
			0: set_window(a, a);
			1: set_window((a > b) ? a : b, (a > b) ? b : a);
			2: set_window('0, TIME_MAX);
			3: set_window((a < b) ? a : b, (a < b) ? b : a);
			4: set_window(TIME_MAX - $urandom_range(1, 50000), TIME_MAX);
			default: begin
				if ($urandom_range(0, 1))
					a = a % 1000000;
				b = a + $urandom_range(1, 200000);
				set_window(a, (b < a) ? TIME_MAX : b);
			end
		endcase
	endtask

	// one sequence of events around the current window; close marks the final one last
	task automatic gen_sequence(input bit close);
		int n;
		int kind;
		logic [63:0] scale;
		logic [TIME_BITS-1:0] t;
		n     = $urandom_range(1, 8);
		kind  = $urandom_range(0, 9);
		scale = (win_hi > win_lo) ? 64'(win_hi - win_lo) : 64'd5000;
		t     = win_lo - TIME_BITS'(64'(rand48()) % (scale / 4 + 2));
		if (kind == 9)
			t = rand48();
		for (int i = 0; i < n; i++) begin
			if (i > 0) begin
				if (kind == 9)
					t = rand48();
				else if (kind == 8 && $urandom_range(0, 2) == 0)
					t = t - TIME_BITS'(64'(rand48()) % (scale / 2 + 2));
				else
					t = t + TIME_BITS'(64'(rand48()) % (scale * 2 / n + 2));
			end
			push_ev(t, 1'($urandom_range(0, 1)), close && (i == n - 1));
		end
	endtask

	initial begin
		int nseq;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		m_tready    = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_addr    = '0;
		cfg_wr_data = '0;
		win_lo      = '0;
		win_hi      = '0;
		held_stamp  = '0;
		held_busy   = 1'b0;
		seq_open    = 1'b0;
		busy_sum    = '0;
		calm        = 1'b0;
		in_gap      = 0;
		out_gap     = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset window is empty
		push_ev(48'd5, 1'b1, 1'b0);
		push_ev(48'd10, 1'b1, 1'b1);
		wait_idle();

		// clipping at both window edges, single event, out-of-window and backward stamps
		set_window(48'd100, 48'd1100);
		push_ev(48'd0, 1'b0, 1'b0);
		push_ev(48'd50, 1'b1, 1'b0);
		push_ev(48'd300, 1'b0, 1'b0);
		push_ev(48'd1000, 1'b1, 1'b0);
		push_ev(48'd1050, 1'b1, 1'b1);
		push_ev(48'd200, 1'b1, 1'b1);
		push_ev(48'd20, 1'b1, 1'b0);
		push_ev(48'd30, 1'b1, 1'b1);
		push_ev(48'd1200, 1'b1, 1'b0);
		push_ev(48'd1300, 1'b0, 1'b1);
		push_ev(48'd900, 1'b1, 1'b0);
		push_ev(48'd400, 1'b1, 1'b0);
		push_ev(48'd600, 1'b0, 1'b1);
		wait_idle();

		// exact halves round up
		set_window(48'd0, 48'd20000);
		push_ev(48'd0, 1'b1, 1'b0);
		push_ev(48'd1, 1'b0, 1'b1);
		push_ev(48'd10, 1'b1, 1'b0);
		push_ev(48'd13, 1'b0, 1'b1);
		wait_idle();

		// full-range window and accumulator saturation via a backward stamp
		set_window('0, TIME_MAX);
		push_ev('0, 1'b1, 1'b0);
		push_ev(TIME_MAX, 1'b1, 1'b0);
		push_ev('0, 1'b1, 1'b0);
		push_ev(TIME_MAX, 1'b1, 1'b1);
		wait_idle();

		// window end moved in the middle of a sequence
		set_window(48'd1000, 48'd2000);
		push_ev(48'd1500, 1'b1, 1'b0);
		wait_idle();
		write_reg(REG_WINDOW_END, 48'd5000);
		push_ev(48'd3000, 1'b0, 1'b1);
		wait_idle();

		// inverted window
		set_window(TIME_MAX, '0);
		push_ev(48'd7, 1'b1, 1'b1);
		wait_idle();
		phase_count = 6;

		// random phases, each under a fresh window
		while (events_queued < EVENT_GOAL) begin
			if (events_queued >= EVENT_GOAL - CALM_TAIL)
				calm = 1'b1;
			random_window();
			nseq = $urandom_range(3, 10);
			for (int k = 0; k < nseq; k++)
				gen_sequence(1'b1);
			if ($urandom_range(0, 3) == 0)
				gen_sequence(1'b0);
			wait_idle();
			phase_count++;
		end

		$display("%0d events in %0d window settings, %0d readings checked, %0d mismatches",
			events_taken, phase_count, readings_seen, mismatches);
		if (mismatches == 0)
			$display("[window_busy_time_meter] OK");
		else
			$display("[window_busy_time_meter] ERROR");
		$finish;
	end

endmodule
